FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the integrity and redundancy check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AIRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define AIRC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/airc_pkg.sv
// Types, codes and constants shared by the integrity and redundancy check modules.
package airc_pkg;

  localparam int unsigned NumLinksDef = 4;

  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned TimeW    = 63;

  localparam logic [7:0] SeqLast2 = 8'd254;
  localparam logic [7:0] SeqLast1 = 8'd255;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_INTEG  = 3'd1,
    ST_SKEW   = 3'd2,
    ST_WINDOW = 3'd3,
    ST_LOAD   = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic take_item;
    logic srch_step;
    logic slot_rd;
    logic capture;
    logic decide;
    logic load_commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic span_zero;
    logic hit;
    logic next_span_zero;
    logic div_busy;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/airc_div.sv
// Radix-2 restoring divider that also tracks the quotient modulo 255.
module airc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o,
  output logic [7:0]  quot_mod_o
);
  import airc_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [7:0]  r255_q, r255_d;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic        qbit;
  logic [8:0]  r2;

  always_comb begin
    shifted = {rem_q[31:0], quo_q[31]};
    trial   = shifted - {1'b0, dvs_q};
    qbit    = (shifted >= {1'b0, dvs_q});
    r2      = {r255_q, 1'b0} + {8'd0, qbit};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    r255_d  = r255_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      r255_d = '0;
    end else if (busy_q) begin
      rem_d  = qbit ? trial : shifted;
      quo_d  = {quo_q[30:0], qbit};
      r255_d = (r2 >= 9'd255) ? 8'(r2 - 9'd255) : r2[7:0];
      cnt_d  = cnt_q - 6'd1;
      busy_d = (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    r255_q <= r255_d;
  end

  assign busy_o     = busy_q;
  assign quot_o     = quo_q;
  assign quot_mod_o = r255_q;

endmodule

FILE: hdl/airc_dp.sv
// Datapath: link tables, per-link state, arrival store, checks and output register.
module airc_dp #(
  parameter int unsigned NUM_LINKS = airc_pkg::NumLinksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  airc_pkg::cmd_t                cmd_i,
  output airc_pkg::sts_t                sts_o,
  input  logic [airc_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [airc_pkg::OutDataW-1:0] m_tdata_o
);
  import airc_pkg::*;

  localparam int unsigned SlotW    = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int unsigned ChanN    = 2 * NUM_LINKS;
  localparam int unsigned ArrDepth = NUM_LINKS * 512;
  localparam int unsigned ArrAw    = $clog2(ArrDepth);

  // Item registers.
  logic [15:0] id_q;
  logic [7:0]  seq_q;
  logic        net_q;
  logic [TimeW-1:0] t_q;
  logic [1:0]  ent_q;
  logic [31:0] skw_in_q;
  logic [31:0] bag_in_q;

  // Search registers.
  logic [SlotW:0]   lo_q, hi_q, mid_q, span_q;
  logic [SlotW:0]   lo_n, hi_n;
  logic [SlotW+1:0] mid_sum;
  logic [SlotW-1:0] slot;

  // Link tables.
  logic [15:0] id_mem  [NUM_LINKS];
  logic [31:0] skw_mem [NUM_LINKS];
  logic [31:0] gap_mem [NUM_LINKS];
  logic [15:0] id_rd_q;
  logic [31:0] skw_rd_q, gap_rd_q;
  logic [SlotW-1:0] wr_slot;
  logic        wr_ok;

  // Per-channel and per-link state.
  logic [7:0]       lis_mem [ChanN];
  logic [7:0]       lis_rd_q;
  logic [ChanN-1:0] fs_q;
  logic [SlotW:0]   ch;
  logic [7:0]       las_mem [NUM_LINKS];
  logic [TimeW-1:0] lat_mem [NUM_LINKS];
  logic [7:0]       las_rd_q;
  logic [TimeW-1:0] lat_rd_q;
  logic [NUM_LINKS-1:0] lav_q;

  // Arrival store and its clearing pass.
  logic [TimeW-1:0] arr_mem [ArrDepth];
  logic [TimeW-1:0] arr_rd_q;
  logic [ArrAw-1:0] clr_q;
  logic [ArrAw-1:0] own_addr, oth_addr;

  // Checks.
  logic        near_q, exp_q;
  logic [63:0] d_oth, d_lat;
  logic [7:0]  las_v;
  logic [TimeW-1:0] lat_v;
  logic [31:0] gap_eff;
  logic        div_busy;
  logic [31:0] quot;
  logic [7:0]  quot_mod;
  logic        integ_ok;
  logic [7:0]  seq_d;
  logic [33:0] win_sum;
  logic [9:0]  m0, m1, m2;
  logic [7:0]  win_mod;
  logic        win_ok;
  status_e     st;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  assign slot     = mid_q[SlotW-1:0];
  assign ch       = {slot, net_q};
  assign own_addr = ArrAw'({slot, net_q, seq_q});
  assign oth_addr = ArrAw'({slot, ~net_q, seq_q});
  assign wr_slot  = SlotW'(ent_q);
  assign wr_ok    = (32'(ent_q) < NUM_LINKS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      id_q     <= s_tdata_i[15:0];
      seq_q    <= s_tdata_i[23:16];
      net_q    <= s_tdata_i[24];
      t_q      <= s_tdata_i[87:25];
      ent_q    <= s_tdata_i[89:88];
      skw_in_q <= s_tdata_i[121:90];
      bag_in_q <= s_tdata_i[153:122];
    end
  end

  // Bounded binary search.
  always_comb begin
    lo_n    = (id_q > id_rd_q) ? mid_q : lo_q;
    hi_n    = (id_q > id_rd_q) ? hi_q : mid_q;
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= '0;
      mid_q  <= '0;
      span_q <= '0;
    end else if (cmd_i.take_item) begin
      lo_q   <= '0;
      hi_q   <= (SlotW+1)'(NUM_LINKS);
      mid_q  <= (SlotW+1)'(NUM_LINKS / 2);
      span_q <= (SlotW+1)'(NUM_LINKS / 2);
    end else if (cmd_i.srch_step) begin
      lo_q   <= lo_n;
      hi_q   <= hi_n;
      mid_q  <= mid_sum[SlotW+1:1];
      span_q <= span_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_commit && wr_ok) begin
      id_mem[wr_slot]  <= id_q;
      skw_mem[wr_slot] <= skw_in_q;
      gap_mem[wr_slot] <= bag_in_q;
    end
    id_rd_q  <= id_mem[slot];
    skw_rd_q <= skw_mem[slot];
    gap_rd_q <= gap_mem[slot];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && integ_ok) begin
      lis_mem[ch] <= seq_q;
    end
    if (cmd_i.decide && (st == ST_ACCEPT)) begin
      las_mem[slot] <= seq_q;
      lat_mem[slot] <= t_q;
    end
    lis_rd_q <= lis_mem[ch];
    las_rd_q <= las_mem[slot];
    lat_rd_q <= lat_mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= '0;
      lav_q <= '0;
    end else if (cmd_i.decide) begin
      if (integ_ok) fs_q[ch] <= 1'b1;
      if (st == ST_ACCEPT) lav_q[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      arr_mem[clr_q] <= '0;
    end else if (cmd_i.slot_rd) begin
      arr_mem[own_addr] <= t_q;
    end
    arr_rd_q <= arr_mem[oth_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + ArrAw'(1);
    end
  end

  // Time comparisons against the skew limit.
  assign las_v   = lav_q[slot] ? las_rd_q : 8'd0;
  assign lat_v   = lav_q[slot] ? lat_rd_q : '0;
  assign d_oth   = {1'b0, t_q} - {1'b0, arr_rd_q};
  assign d_lat   = {1'b0, t_q} - {1'b0, lat_v};
  assign gap_eff = (gap_rd_q == 32'd0) ? 32'd1 : gap_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      near_q <= ($signed(d_oth) < $signed({32'd0, skw_rd_q}));
      exp_q  <= ($signed(d_lat) > $signed({32'd0, skw_rd_q}));
    end
  end

  airc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture),
    .dividend_i (skw_rd_q),
    .divisor_i  (gap_eff),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .quot_mod_o (quot_mod)
  );

  // Integrity check and sequence window.
  always_comb begin
    seq_d = seq_q - lis_rd_q;
    if ((seq_q == 8'd0) || !fs_q[ch]) begin
      integ_ok = 1'b1;
    end else if (lis_rd_q > seq_q) begin
      integ_ok = ((lis_rd_q == SeqLast2) && (seq_q == 8'd1)) ||
                 ((lis_rd_q == SeqLast1) && ((seq_q == 8'd1) || (seq_q == 8'd2)));
    end else begin
      integ_ok = (seq_d == 8'd1) || (seq_d == 8'd2);
    end

    win_sum = {26'd0, las_v} + {2'b00, quot} + 34'd2;
    // (last + q + 2) mod 255 from the quotient residue kept by the divider.
    m0 = ((las_v == SeqLast1) ? 10'd0 : {2'b00, las_v}) + {2'b00, quot_mod} + 10'd2;
    m1 = (m0 >= 10'd255) ? m0 - 10'd255 : m0;
    m2 = (m1 >= 10'd255) ? m1 - 10'd255 : m1;
    win_mod = m2[7:0];
    if (win_sum[33:8] != '0) begin
      win_ok = (seq_q > las_v) || ((seq_q >= 8'd1) && (seq_q <= win_mod));
    end else begin
      win_ok = (seq_q > las_v) && (seq_q <= win_sum[7:0]);
    end

    if (!integ_ok) begin
      st = ST_INTEG;
    end else if (near_q) begin
      st = ST_SKEW;
    end else if (exp_q || win_ok) begin
      st = ST_ACCEPT;
    end else begin
      st = ST_WINDOW;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.decide || cmd_i.load_commit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      m_data_q <= {2'b00, st, (st == ST_ACCEPT), mid_q[1:0]};
    end else if (cmd_i.load_commit) begin
      m_data_q <= {2'b00, ST_LOAD, 1'b0, ent_q};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  assign sts_o.clr_done       = (clr_q == ArrAw'(ArrDepth - 1));
  assign sts_o.span_zero      = (span_q == '0);
  assign sts_o.hit            = (id_q == id_rd_q);
  assign sts_o.next_span_zero = (span_q[SlotW:1] == '0);
  assign sts_o.div_busy       = div_busy;
  assign sts_o.out_busy       = m_valid_q && !m_tready_i;

endmodule

FILE: hdl/airc_ctrl.sv
// Controller state machine that sequences clearing, search, lookup, division and commit.
module airc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_load_i,
  input  airc_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output airc_pkg::cmd_t cmd_o
);
  import airc_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_SRCH_RD  = 9'b000000100,
    S_SRCH_CMP = 9'b000001000,
    S_SLOT_RD  = 9'b000010000,
    S_CAPT     = 9'b000100000,
    S_DIV      = 9'b001000000,
    S_DECIDE   = 9'b010000000,
    S_LOAD     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d = in_load_i ? S_LOAD : S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        state_d = sts_i.span_zero ? S_SLOT_RD : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts_i.hit) begin
          state_d = S_SLOT_RD;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d = sts_i.next_span_zero ? S_SLOT_RD : S_SRCH_RD;
        end
      end
      S_SLOT_RD: begin
        cmd_o.slot_rd = 1'b1;
        state_d = S_CAPT;
      end
      S_CAPT: begin
        cmd_o.capture = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.out_busy) begin
          cmd_o.decide = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/afdx_integrity_redundancy_check_core.sv
// Top level of the dual-network integrity check and redundancy management filter.
// After reset the block clears its arrival store of 512 * NUM_LINKS entries (2048
// at the default), one entry a cycle, and takes no transfer until then.
// Items are handled one at a time: a table load is committed from its load state; a
// frame goes through the search, which ends early on a hit, the slot read, capture,
// the 32-step radix-2 divider that forms skew / gap for the sequence window, and the
// decision. Either kind waits in its last state while the previous result has not
// yet been taken.
// The result sits in an output register, so the next item is taken while it waits.
`include "assert_macros.svh"

module afdx_integrity_redundancy_check_core #(
  parameter int unsigned NUM_LINKS = airc_pkg::NumLinksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] vl_id, [23:16] seq_num, [24] network, [87:25] frame time stamp,
  // [89:88] entry_index, [121:90] skew_limit, [153:122] bag_period, rest zero
  input  logic [airc_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] table slot found, [2] accepted, [5:3] status, rest zero
  output logic [airc_pkg::OutDataW-1:0] m_axis_tdata
);
  import airc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  airc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_load_i  (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  airc_dp #(
    .NUM_LINKS (NUM_LINKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

  logic       res_wr;
  logic [2:0] out_st;
  logic       out_acc;
  logic       out_is_load;

  assign res_wr      = cmd.decide || cmd.load_commit;
  assign out_st      = m_axis_tdata[5:3];
  assign out_acc     = m_axis_tdata[2];
  assign out_is_load = (out_st == ST_LOAD) && !out_acc;

  `AIRC_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `AIRC_ASSERT(a_no_overwrite, res_wr |-> !sts.out_busy, "result written over one not taken")
  `AIRC_ASSERT(a_clear_blocks, cmd.clr_step |-> !s_axis_tready, "transfer during clearing")
  `AIRC_ASSERT_NEXT(a_load_status, cmd.load_commit, m_axis_tvalid && out_is_load, "bad load")
  `AIRC_ASSERT(a_accept_flag, m_axis_tvalid |-> (out_acc == (out_st == ST_ACCEPT)), "bad flag")

endmodule
